>>> src/rld_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rld_pkg
// Shared types and constants of the raster line drawer.
// ----------------------------------------------------------------------------
package rld_pkg;

  // Default sizing of the pixel store.
  localparam int unsigned DEF_MAX_WIDTH  = 256;
  localparam int unsigned DEF_MAX_HEIGHT = 256;
  localparam int unsigned DEF_PIXEL_BITS = 8;

  // Fixed field widths.
  localparam int unsigned COORD_W  = 8;
  localparam int unsigned VALUE_W  = 8;
  localparam int unsigned DIM_W    = 9;
  localparam int unsigned CFG_W    = 32;
  localparam int unsigned CFG_AW   = 3;
  // Error term of the line stepper; covers -2*255 .. 2*255 with margin.
  localparam int unsigned ERR_W    = 12;

  localparam logic [DIM_W-1:0] DIM_RESET = 9'd256;

  // Configuration register indexes (paddr[2]).
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  typedef enum logic [1:0] {
    ACT_MOVE = 2'd0,
    ACT_DRAW = 2'd1,
    ACT_READ = 2'd2
  } action_t;

endpackage

>>> src/raster_line_drawer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// raster_line_drawer_core
// Bresenham line rasterizer writing into an on-chip pixel store.
// ----------------------------------------------------------------------------
// An item is taken at a rising edge with start high and busy low. A move sets
// the pen and is done in the accept cycle. A draw steps along the major axis
// and writes one pixel per cycle through the single write port of the pixel
// store; busy stays high while the line is stepped, up to its last pixel. A
// read addresses the store in the accept cycle; the store's registered read
// data appears in the following cycle on out_read_value with out_valid high
// for that one cycle, and busy is high during it. Pixels outside
// raster_width x raster_height are not written and read back as zero.
// The receiver cannot stall; out_valid is a single-cycle strobe.
// After reset the block sweeps every entry of the store to zero, one entry
// per cycle, with busy high.
// The APB port can be written and read at any time, the sweep included, but
// registers are only to be changed while no item is in progress.
// ----------------------------------------------------------------------------
module raster_line_drawer_core #(
  parameter int unsigned MAX_WIDTH  = rld_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = rld_pkg::DEF_MAX_HEIGHT,
  parameter int unsigned PIXEL_BITS = rld_pkg::DEF_PIXEL_BITS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // Command channel
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   in_action,
  input  logic [rld_pkg::COORD_W-1:0]  in_target_x,
  input  logic [rld_pkg::COORD_W-1:0]  in_target_y,
  input  logic [rld_pkg::VALUE_W-1:0]  in_pixel_value,
  // Result channel
  output logic                         out_valid,
  output logic [rld_pkg::VALUE_W-1:0]  out_read_value,
  // Configuration port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [rld_pkg::CFG_AW-1:0]   paddr,
  input  logic [rld_pkg::CFG_W-1:0]    pwdata,
  output logic [rld_pkg::CFG_W-1:0]    prdata,
  output logic                         pready
);

  localparam int unsigned DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned EXT_W = (PIXEL_BITS > rld_pkg::VALUE_W) ? PIXEL_BITS
                                                                   : rld_pkg::VALUE_W;
  localparam int unsigned CW    = rld_pkg::COORD_W;
  localparam int unsigned EW    = rld_pkg::ERR_W;

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_DRAW  = 4'b0100,
    ST_READ  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  logic [rld_pkg::DIM_W-1:0] width_r, height_r;
  logic [CW-1:0]             pen_x_r, pen_y_r;
  logic [AW-1:0]             clr_addr_r;

  // Line stepper
  logic [CW-1:0]         cur_x_r, cur_y_r, cnt_r;
  logic signed [EW-1:0]  err_r, minor2_r, diff_r;
  logic                  x_major_r, sx_neg_r, sy_neg_r;
  logic [PIXEL_BITS-1:0] val_r;
  logic                  rd_oob_r;

  // Pixel store
  logic [PIXEL_BITS-1:0] mem [DEPTH];
  logic [PIXEL_BITS-1:0] mem_q_r;
  logic                  mem_we, mem_re;
  logic [AW-1:0]         mem_waddr, mem_raddr;
  logic [PIXEL_BITS-1:0] mem_wdata;

  logic accept;
  logic cfg_wr;

  assign accept = start && !busy;
  assign busy   = (state_r != ST_IDLE);
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  function automatic logic in_raster(input logic [CW-1:0] x, input logic [CW-1:0] y,
                                     input logic [rld_pkg::DIM_W-1:0] w,
                                     input logic [rld_pkg::DIM_W-1:0] h);
    logic ok;
    ok = ({1'b0, x} < w) && (32'(x) < 32'(MAX_WIDTH)) &&
         ({1'b0, y} < h) && (32'(y) < 32'(MAX_HEIGHT));
    return ok;
  endfunction

  function automatic logic [AW-1:0] pix_addr(input logic [CW-1:0] x,
                                             input logic [CW-1:0] y);
    logic [31:0] full;
    full = 32'(y) * 32'(MAX_WIDTH) + 32'(x);
    return full[AW-1:0];
  endfunction

  // --------------------------------------------------------------------------
  // Draw setup from the pen and the target
  // --------------------------------------------------------------------------
  logic [CW-1:0]        hx, hy, major, minor;
  logic                 x_major;
  logic signed [EW-1:0] minor2, err_init, diff_init;

  always_comb begin
    hx        = (in_target_x > pen_x_r) ? in_target_x - pen_x_r : pen_x_r - in_target_x;
    hy        = (in_target_y > pen_y_r) ? in_target_y - pen_y_r : pen_y_r - in_target_y;
    x_major   = (hx > hy);
    major     = x_major ? hx : hy;
    minor     = x_major ? hy : hx;
    minor2    = $signed(EW'({minor, 1'b0}));
    err_init  = minor2 - $signed(EW'(major));
    diff_init = minor2 - $signed(EW'({major, 1'b0}));
  end

  // --------------------------------------------------------------------------
  // One Bresenham step
  // --------------------------------------------------------------------------
  logic          err_pos, step_x, step_y;
  logic [CW-1:0] cur_x_nxt, cur_y_nxt;
  logic signed [EW-1:0] err_nxt;

  always_comb begin
    err_pos   = !err_r[EW-1] && (err_r != '0);
    step_x    = x_major_r || err_pos;
    step_y    = !x_major_r || err_pos;
    cur_x_nxt = !step_x ? cur_x_r : (sx_neg_r ? cur_x_r - 1'b1 : cur_x_r + 1'b1);
    cur_y_nxt = !step_y ? cur_y_r : (sy_neg_r ? cur_y_r - 1'b1 : cur_y_r + 1'b1);
    err_nxt   = err_pos ? err_r + diff_r : err_r + minor2_r;
  end

  // --------------------------------------------------------------------------
  // Control
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (clr_addr_r == AW'(DEPTH - 1)) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (accept && in_action == rld_pkg::ACT_DRAW) state_nxt = ST_DRAW;
        else if (accept && in_action == rld_pkg::ACT_READ) state_nxt = ST_READ;
      end
      ST_DRAW:  if (cnt_r == '0) state_nxt = ST_IDLE;
      ST_READ:  state_nxt = ST_IDLE;
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      clr_addr_r <= '0;
      pen_x_r    <= '0;
      pen_y_r    <= '0;
      width_r    <= rld_pkg::DIM_RESET;
      height_r   <= rld_pkg::DIM_RESET;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) clr_addr_r <= clr_addr_r + 1'b1;
      if (cfg_wr) begin
        if (paddr[2] == rld_pkg::REG_HEIGHT) height_r <= pwdata[rld_pkg::DIM_W-1:0];
        else                                 width_r  <= pwdata[rld_pkg::DIM_W-1:0];
      end
      if (accept && (in_action == rld_pkg::ACT_MOVE || in_action == rld_pkg::ACT_DRAW)) begin
        pen_x_r <= in_target_x;
        pen_y_r <= in_target_y;
      end
    end
  end

  // Stepper and read-side payload registers.
  logic [EXT_W-1:0] val_ext;
  assign val_ext = EXT_W'(in_pixel_value);

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && accept) begin
      cur_x_r   <= pen_x_r;
      cur_y_r   <= pen_y_r;
      cnt_r     <= major;
      err_r     <= err_init;
      minor2_r  <= minor2;
      diff_r    <= diff_init;
      x_major_r <= x_major;
      sx_neg_r  <= !(in_target_x > pen_x_r);
      sy_neg_r  <= !(in_target_y > pen_y_r);
      val_r     <= val_ext[PIXEL_BITS-1:0];
      rd_oob_r  <= !in_raster(in_target_x, in_target_y, width_r, height_r);
    end else if (state_r == ST_DRAW) begin
      cur_x_r <= cur_x_nxt;
      cur_y_r <= cur_y_nxt;
      err_r   <= err_nxt;
      cnt_r   <= cnt_r - 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Pixel store ports
  // --------------------------------------------------------------------------
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_addr_r;
    mem_wdata = '0;
    if (state_r == ST_CLEAR) begin
      mem_we = 1'b1;
    end else if (state_r == ST_DRAW) begin
      mem_we    = in_raster(cur_x_r, cur_y_r, width_r, height_r);
      mem_waddr = pix_addr(cur_x_r, cur_y_r);
      mem_wdata = val_r;
    end
    mem_re    = accept && (in_action == rld_pkg::ACT_READ);
    mem_raddr = pix_addr(in_target_x, in_target_y);
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) mem_q_r <= mem[mem_raddr];
  end

  // --------------------------------------------------------------------------
  // Outputs
  // --------------------------------------------------------------------------
  logic [EXT_W-1:0] rd_ext;
  assign rd_ext         = EXT_W'(mem_q_r);
  assign out_valid      = (state_r == ST_READ);
  assign out_read_value = rd_oob_r ? '0 : rd_ext[rld_pkg::VALUE_W-1:0];

  assign prdata = (paddr[2] == rld_pkg::REG_HEIGHT) ? rld_pkg::CFG_W'(height_r)
                                                    : rld_pkg::CFG_W'(width_r);

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  a_read_result: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_action == rld_pkg::ACT_READ) |=> out_valid)
    else $error("read item did not produce a result in the next cycle");

  a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE || state_r == ST_READ) |-> !mem_we)
    else $error("pixel store written outside of clear or draw");

  a_line_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DRAW && cnt_r == '0) |-> (cur_x_r == pen_x_r && cur_y_r == pen_y_r))
    else $error("line stepper did not end on the target");

endmodule
